### hw/rtl/lmsc_pkg.sv
// Shared types, register codes and reset values for the light mode switch controller.
// Used by lmsc_step and by the top level light_mode_switch_controller.
`timescale 1ns / 1ps
`default_nettype none
package lmsc_pkg;

  localparam int CLOCK_BITS_DEF = 32;
  localparam int LEVEL_W        = 12;
  localparam int TIME_W         = 31;
  localparam int CFG_DATA_W     = 31;
  localparam int CFG_INDEX_W    = 4;
  localparam int LAMP_W         = 7;
  localparam int IN_DATA_W      = 16;
  localparam int OUT_DATA_W     = 16;

  localparam logic [LEVEL_W-1:0] BAND_LOW  = 12'd1400;
  localparam logic [LEVEL_W-1:0] BAND_HIGH = 12'd1600;

  localparam logic [LEVEL_W-1:0] PRESS_UP_RST    = 12'd1800;
  localparam logic [LEVEL_W-1:0] PRESS_DOWN_RST  = 12'd1200;
  localparam logic [TIME_W-1:0]  LONG_HOLD_RST   = 31'd1000000;
  localparam logic [TIME_W-1:0]  SHORT_HOLD_RST  = 31'd50000;
  localparam logic [TIME_W-1:0]  BEACON_ON_RST   = 31'd100000;
  localparam logic [TIME_W-1:0]  BEACON_OFF_RST  = 31'd100000;
  localparam logic [TIME_W-1:0]  BEACON_PAUSE_RST = 31'd200000;
  localparam logic [TIME_W-1:0]  CONFIG_BLINK_RST = 31'd500000;

  localparam int LV_POS   = 0;
  localparam int LV_LOW   = 1;
  localparam int LV_HIGH  = 2;
  localparam int LV_RAMP  = 3;
  localparam int LV_SIDE1 = 4;
  localparam int LV_SIDE2 = 5;
  localparam int LV_REAR  = 6;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PRESS_UP     = 4'd0,
    REG_PRESS_DOWN   = 4'd1,
    REG_LONG_HOLD    = 4'd2,
    REG_SHORT_HOLD   = 4'd3,
    REG_BEACON_ON    = 4'd4,
    REG_BEACON_OFF   = 4'd5,
    REG_BEACON_PAUSE = 4'd6,
    REG_CONFIG_BLINK = 4'd7
  } lmsc_reg_t;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_BEACON = 2'd1,
    KIND_NORMAL = 2'd2,
    KIND_CONFIG = 2'd3
  } lmsc_kind_t;

  typedef enum logic [1:0] {
    PH_NEUTRAL = 2'd0,
    PH_UP      = 2'd1,
    PH_DOWN    = 2'd2,
    PH_WAIT    = 2'd3
  } lmsc_phase_t;

  typedef enum logic [1:0] {
    SD_OFF    = 2'd0,
    SD_FOLLOW = 2'd1,
    SD_BEACON = 2'd2,
    SD_CONFIG = 2'd3
  } lmsc_side_t;

  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_POSITION = 3'd1,
    MODE_LOW      = 3'd2,
    MODE_HIGH     = 3'd3,
    MODE_RAMP     = 3'd4
  } lmsc_mode_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] press_up_level;
    logic [LEVEL_W-1:0] press_down_level;
    logic [TIME_W-1:0]  long_hold_us;
    logic [TIME_W-1:0]  short_hold_us;
    logic [TIME_W-1:0]  beacon_on_us;
    logic [TIME_W-1:0]  beacon_off_us;
    logic [TIME_W-1:0]  beacon_pause_us;
    logic [TIME_W-1:0]  config_blink_us;
  } lmsc_cfg_t;

  typedef struct packed {
    lmsc_phase_t       phase;
    lmsc_mode_t        mode;
    lmsc_side_t        side;
    logic [2:0]        blink_step;
    logic [LAMP_W-1:0] levels;
  } lmsc_ctl_t;

  typedef struct packed {
    logic              lamps_lit;
    lmsc_mode_t        mode_now;
    logic              fog_off_pulse;
    logic [LAMP_W-1:0] levels;
  } lmsc_result_t;

endpackage
`default_nettype wire

### hw/rtl/lmsc_step.sv
// Next-state and result logic for one request of the light mode switch controller.
// Purely combinational; depends on lmsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lmsc_step #(
  parameter int CLOCK_BITS = lmsc_pkg::CLOCK_BITS_DEF
) (
  input  lmsc_pkg::lmsc_cfg_t             cfg,
  input  lmsc_pkg::lmsc_kind_t            kind,
  input  logic [lmsc_pkg::LEVEL_W-1:0]    channel_value,
  input  lmsc_pkg::lmsc_ctl_t             ctl,
  input  logic [CLOCK_BITS-1:0]           now_clock,
  input  logic [CLOCK_BITS-1:0]           side_due_time,
  input  logic [CLOCK_BITS-1:0]           press_start,
  output lmsc_pkg::lmsc_ctl_t             ctl_nxt,
  output logic [CLOCK_BITS-1:0]           now_clock_nxt,
  output logic [CLOCK_BITS-1:0]           side_due_time_nxt,
  output logic [CLOCK_BITS-1:0]           press_start_nxt,
  output lmsc_pkg::lmsc_result_t          result
);
  import lmsc_pkg::*;

  localparam int CMP_W = (CLOCK_BITS > TIME_W) ? CLOCK_BITS : TIME_W;

  function automatic logic later_than(input logic [CLOCK_BITS-1:0] now_v,
                                      input logic [CLOCK_BITS-1:0] mark,
                                      input logic [TIME_W-1:0] limit);
    logic [CLOCK_BITS-1:0] d;
    d = now_v - mark;
    return !d[CLOCK_BITS-1] && (CMP_W'(d) > CMP_W'(limit));
  endfunction

  logic [CLOCK_BITS-1:0] now_tick;
  logic [TIME_W-1:0]     beacon_wait;
  logic                  in_band;
  logic                  fog;
  logic                  lit;

  assign now_tick = now_clock + CLOCK_BITS'(1);
  assign in_band  = (channel_value > BAND_LOW) && (channel_value < BAND_HIGH);

  always_comb begin
    if (!ctl.blink_step[0]) begin
      beacon_wait = cfg.beacon_on_us;
    end else if (!ctl.blink_step[1]) begin
      beacon_wait = cfg.beacon_off_us;
    end else begin
      beacon_wait = cfg.beacon_pause_us;
    end
  end

  always_comb begin
    ctl_nxt           = ctl;
    now_clock_nxt     = now_clock;
    side_due_time_nxt = side_due_time;
    press_start_nxt   = press_start;
    fog               = 1'b0;
    lit               = 1'b0;
    unique case (kind)
      KIND_TICK: begin
        now_clock_nxt = now_tick;
        if (ctl.side == SD_BEACON && later_than(now_tick, side_due_time, '0)) begin
          if (ctl.blink_step[2]) begin
            ctl_nxt.levels[LV_SIDE2] = !ctl.blink_step[0];
          end else begin
            ctl_nxt.levels[LV_SIDE1] = !ctl.blink_step[0];
          end
          side_due_time_nxt  = now_tick + CLOCK_BITS'(beacon_wait);
          ctl_nxt.blink_step = ctl.blink_step + 3'd1;
        end
        if (ctl.side == SD_CONFIG && later_than(now_tick, side_due_time, '0)) begin
          if (ctl.blink_step == 3'd0) begin
            ctl_nxt.levels[LV_SIDE2] = 1'b1;
            ctl_nxt.blink_step       = 3'd1;
          end else begin
            ctl_nxt.levels[LV_SIDE2] = 1'b0;
            ctl_nxt.blink_step       = 3'd0;
          end
          side_due_time_nxt = now_tick + CLOCK_BITS'(cfg.config_blink_us);
        end
        unique case (ctl.phase)
          PH_NEUTRAL: begin
            if (channel_value > cfg.press_up_level) begin
              ctl_nxt.phase   = PH_UP;
              press_start_nxt = now_tick;
            end else if (channel_value < cfg.press_down_level) begin
              ctl_nxt.phase           = PH_DOWN;
              ctl_nxt.levels[LV_RAMP] = 1'b1;
            end
          end
          PH_UP: begin
            if (later_than(now_tick, press_start, cfg.long_hold_us)) begin
              ctl_nxt.phase = PH_WAIT;
              unique case (ctl.mode)
                MODE_POSITION: begin
                  ctl_nxt.mode           = MODE_OFF;
                  fog                    = 1'b1;
                  ctl_nxt.levels[LV_POS] = 1'b0;
                  if (ctl.side == SD_FOLLOW) begin
                    ctl_nxt.levels[LV_SIDE1] = 1'b0;
                    ctl_nxt.levels[LV_SIDE2] = 1'b0;
                    ctl_nxt.side             = SD_OFF;
                  end
                end
                MODE_LOW: begin
                  ctl_nxt.mode            = MODE_POSITION;
                  ctl_nxt.levels[LV_LOW]  = 1'b0;
                  ctl_nxt.levels[LV_REAR] = 1'b0;
                end
                MODE_HIGH: begin
                  ctl_nxt.mode            = MODE_LOW;
                  ctl_nxt.levels[LV_HIGH] = 1'b0;
                  ctl_nxt.levels[LV_RAMP] = 1'b0;
                end
                MODE_RAMP: begin
                  ctl_nxt.mode            = MODE_HIGH;
                  ctl_nxt.levels[LV_RAMP] = 1'b0;
                end
                default: begin
                end
              endcase
            end else if (in_band) begin
              ctl_nxt.phase = PH_NEUTRAL;
              if (later_than(now_tick, press_start, cfg.short_hold_us)) begin
                unique case (ctl.mode)
                  MODE_OFF: begin
                    ctl_nxt.mode           = MODE_POSITION;
                    ctl_nxt.levels[LV_POS] = 1'b1;
                    if (ctl.side != SD_BEACON && ctl.side != SD_CONFIG) begin
                      ctl_nxt.levels[LV_SIDE1] = 1'b1;
                      ctl_nxt.levels[LV_SIDE2] = 1'b1;
                      ctl_nxt.side             = SD_FOLLOW;
                    end
                  end
                  MODE_POSITION: begin
                    ctl_nxt.mode            = MODE_LOW;
                    ctl_nxt.levels[LV_LOW]  = 1'b1;
                    ctl_nxt.levels[LV_REAR] = 1'b1;
                  end
                  MODE_LOW: begin
                    ctl_nxt.mode            = MODE_HIGH;
                    ctl_nxt.levels[LV_HIGH] = 1'b1;
                  end
                  MODE_HIGH: begin
                    ctl_nxt.mode            = MODE_RAMP;
                    ctl_nxt.levels[LV_RAMP] = 1'b1;
                  end
                  default: begin
                  end
                endcase
              end
            end
          end
          PH_DOWN: begin
            if (in_band) begin
              ctl_nxt.phase = PH_NEUTRAL;
              if (ctl.mode != MODE_RAMP) begin
                ctl_nxt.levels[LV_RAMP] = 1'b0;
              end
            end
          end
          default: begin
            if (in_band) begin
              ctl_nxt.phase = PH_NEUTRAL;
            end
          end
        endcase
      end
      KIND_BEACON, KIND_CONFIG: begin
        ctl_nxt.side       = (kind == KIND_BEACON) ? SD_BEACON : SD_CONFIG;
        ctl_nxt.blink_step = 3'd0;
        side_due_time_nxt  = now_clock;
      end
      default: begin
        lit                      = (ctl.mode != MODE_OFF);
        ctl_nxt.side             = lit ? SD_FOLLOW : SD_OFF;
        ctl_nxt.levels[LV_SIDE1] = lit;
        ctl_nxt.levels[LV_SIDE2] = lit;
      end
    endcase
  end

  assign result.levels        = ctl_nxt.levels;
  assign result.fog_off_pulse = fog;
  assign result.mode_now      = ctl_nxt.mode;
  assign result.lamps_lit     = (ctl_nxt.mode != MODE_OFF);

endmodule
`default_nettype wire

### hw/rtl/light_mode_switch_controller.sv
// Top level of the light mode switch controller: configuration registers, state
// registers and a two-entry result buffer. Depends on lmsc_pkg and lmsc_step.
`timescale 1ns / 1ps
`default_nettype none
// Every accepted request, tick or side command, produces exactly one result, and
// one request is taken in every clock cycle while in_tready is high. The request is
// evaluated in one pass of logic against the state registers and the result goes
// into a two-entry output buffer, so in_tready falls only when two results are
// waiting.
module light_mode_switch_controller #(
  parameter int CLOCK_BITS = lmsc_pkg::CLOCK_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0: channel_value[11:0], zero fill.
  input  logic [lmsc_pkg::IN_DATA_W-1:0]      in_tdata,
  // Fields from bit 0: kind[1:0].
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0: position_lamp, low_beam_lamp, high_beam_lamp, ramp_lamp,
  // side_lamp_one, side_lamp_two, rear_lamp, fog_off_pulse, mode_now[2:0],
  // lamps_lit, zero fill.
  output logic [lmsc_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [lmsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lmsc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import lmsc_pkg::*;

  lmsc_cfg_t             cfg_r;
  lmsc_ctl_t             ctl_r;
  lmsc_ctl_t             ctl_nxt;
  logic [CLOCK_BITS-1:0] now_clock_r;
  logic [CLOCK_BITS-1:0] now_clock_nxt;
  logic [CLOCK_BITS-1:0] side_due_time_r;
  logic [CLOCK_BITS-1:0] side_due_time_nxt;
  logic [CLOCK_BITS-1:0] press_start_r;
  logic [CLOCK_BITS-1:0] press_start_nxt;
  lmsc_result_t          result;
  lmsc_result_t          out_r;
  lmsc_result_t          skid_r;
  logic                  out_valid_r;
  logic                  skid_valid_r;
  logic                  push;
  logic                  pop;

  assign in_tready = !skid_valid_r;
  assign push      = in_tvalid && in_tready;
  assign pop       = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_up_level   <= PRESS_UP_RST;
      cfg_r.press_down_level <= PRESS_DOWN_RST;
      cfg_r.long_hold_us     <= LONG_HOLD_RST;
      cfg_r.short_hold_us    <= SHORT_HOLD_RST;
      cfg_r.beacon_on_us     <= BEACON_ON_RST;
      cfg_r.beacon_off_us    <= BEACON_OFF_RST;
      cfg_r.beacon_pause_us  <= BEACON_PAUSE_RST;
      cfg_r.config_blink_us  <= CONFIG_BLINK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRESS_UP:     cfg_r.press_up_level   <= cfg_wdata[LEVEL_W-1:0];
        REG_PRESS_DOWN:   cfg_r.press_down_level <= cfg_wdata[LEVEL_W-1:0];
        REG_LONG_HOLD:    cfg_r.long_hold_us     <= cfg_wdata[TIME_W-1:0];
        REG_SHORT_HOLD:   cfg_r.short_hold_us    <= cfg_wdata[TIME_W-1:0];
        REG_BEACON_ON:    cfg_r.beacon_on_us     <= cfg_wdata[TIME_W-1:0];
        REG_BEACON_OFF:   cfg_r.beacon_off_us    <= cfg_wdata[TIME_W-1:0];
        REG_BEACON_PAUSE: cfg_r.beacon_pause_us  <= cfg_wdata[TIME_W-1:0];
        REG_CONFIG_BLINK: cfg_r.config_blink_us  <= cfg_wdata[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lmsc_step #(
    .CLOCK_BITS(CLOCK_BITS)
  ) u_step (
    .cfg               (cfg_r),
    .kind              (lmsc_kind_t'(in_tuser)),
    .channel_value     (in_tdata[LEVEL_W-1:0]),
    .ctl               (ctl_r),
    .now_clock         (now_clock_r),
    .side_due_time     (side_due_time_r),
    .press_start       (press_start_r),
    .ctl_nxt           (ctl_nxt),
    .now_clock_nxt     (now_clock_nxt),
    .side_due_time_nxt (side_due_time_nxt),
    .press_start_nxt   (press_start_nxt),
    .result            (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.phase      <= PH_NEUTRAL;
      ctl_r.mode       <= MODE_OFF;
      ctl_r.side       <= SD_OFF;
      ctl_r.blink_step <= 3'd0;
      ctl_r.levels     <= '0;
      now_clock_r      <= '0;
      side_due_time_r  <= '0;
      press_start_r    <= '0;
    end else if (push) begin
      ctl_r           <= ctl_nxt;
      now_clock_r     <= now_clock_nxt;
      side_due_time_r <= side_due_time_nxt;
      press_start_r   <= press_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        skid_valid_r <= push;
      end else begin
        out_valid_r <= push;
      end
    end else if (!out_valid_r) begin
      out_valid_r <= push;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        out_r  <= skid_r;
        skid_r <= result;
      end else begin
        out_r <= result;
      end
    end else if (!out_valid_r) begin
      out_r <= result;
    end else if (push) begin
      skid_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_r);

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a head entry");

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[10:8] <= MODE_RAMP))
    else $error("result mode out of range");

  a_lit_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[11] == (out_tdata[10:8] != MODE_OFF)))
    else $error("lamps_lit disagrees with mode");

  a_fog_only_to_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[7]) |-> (out_tdata[10:8] == MODE_OFF && !out_tdata[0]))
    else $error("fog pulse without a step to off");

endmodule
`default_nettype wire
